FILE: sv/pfb_pkg.sv
// ----------------------------------------------------------------------------
// pfb_pkg
// shared types and constants of the polled frame builder
// ----------------------------------------------------------------------------
package pfb_pkg;

  // input item kinds
  localparam logic [1:0] KindTick  = 2'd0;
  localparam logic [1:0] KindLight = 2'd1;
  localparam logic [1:0] KindAux   = 2'd2;
  localparam logic [1:0] KindServo = 2'd3;

  // configuration register indexes
  localparam logic [2:0] RegProtocolCode   = 3'd0;
  localparam logic [2:0] RegLightOnlyCode  = 3'd1;
  localparam logic [2:0] RegLightServoCode = 3'd2;
  localparam logic [2:0] RegCrcPolynomial  = 3'd3;
  localparam logic [2:0] RegPollingMs      = 3'd4;

  // servo words that may be written (storage and frame command always hold two)
  localparam int unsigned ServoCount = 2;

  // elapsed counter
  localparam int unsigned ElapsedW = 17;
  localparam logic [ElapsedW-1:0] ElapsedMax = {ElapsedW{1'b1}};

  // command queue between front and back
  localparam int unsigned CmdDepth = 2;
  localparam int unsigned CmdPtrW  = $clog2(CmdDepth);
  localparam int unsigned CmdCntW  = $clog2(CmdDepth + 1);

  // frame layout
  localparam logic [3:0] ShortLast = 4'd3;
  localparam logic [3:0] LongLast  = 4'd8;
  localparam logic [15:0] CrcInit  = 16'hFFFF;

  typedef struct packed {
    logic [7:0]  protocol_code;
    logic [7:0]  light_only_code;
    logic [7:0]  light_servo_code;
    logic [15:0] crc_polynomial;
    logic [15:0] polling_ms;
  } cfg_t;

  // one frame to send, snapshot of the state at the sending tick
  typedef struct packed {
    logic        long_frame;
    logic [7:0]  code;
    logic [7:0]  light;
    logic [7:0]  aux;
    logic [15:0] servo0;
    logic [15:0] servo1;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

endpackage

FILE: sv/pfb_front.sv
// ----------------------------------------------------------------------------
// pfb_front
// accepts items, keeps the masks, servo words and tick counter, and queues
// a frame command on each tick that sends
// ----------------------------------------------------------------------------
module pfb_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  pfb_pkg::cfg_t cfg_i,
  input  logic          accept_i,
  input  logic [1:0]    kind_i,
  input  logic [2:0]    option_i,
  input  logic          bit_value_i,
  input  logic [15:0]   servo_value_i,
  output logic          cmd_push_o,
  output pfb_pkg::cmd_t cmd_o
);
  import pfb_pkg::*;

  logic [7:0]          light_q, light_d, aux_q, aux_d, bit_sel;
  logic [15:0]         servo_q [2];
  logic                waiting_q, waiting_d, waiting_tick;
  logic [ElapsedW-1:0] elapsed_q, elapsed_d, elapsed_inc;
  logic                is_short, is_long, send;

  // tick evaluation
  assign bit_sel     = 8'(1) << option_i;
  assign elapsed_inc = (elapsed_q == ElapsedMax) ? elapsed_q : elapsed_q + 1'b1;
  assign waiting_tick = waiting_q && !(elapsed_inc > {1'b0, cfg_i.polling_ms});
  assign is_short    = (cfg_i.protocol_code == cfg_i.light_only_code);
  assign is_long     = !is_short && (cfg_i.protocol_code == cfg_i.light_servo_code);
  assign send        = accept_i && (kind_i == KindTick) && !waiting_tick &&
                       (is_short || is_long);

  // next state of masks and counter
  always_comb begin
    light_d   = light_q;
    aux_d     = aux_q;
    waiting_d = waiting_q;
    elapsed_d = elapsed_q;
    case (kind_i)
      KindTick: begin
        if (send) begin
          waiting_d = 1'b1;
          elapsed_d = '0;
        end else begin
          waiting_d = waiting_tick;
          elapsed_d = elapsed_inc;
        end
      end
      KindLight: light_d = bit_value_i ? (light_q | bit_sel) : (light_q & ~bit_sel);
      KindAux:   aux_d   = bit_value_i ? (aux_q | bit_sel) : (aux_q & ~bit_sel);
      default: ;
    endcase
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      light_q    <= '0;
      aux_q      <= '0;
      servo_q[0] <= '0;
      servo_q[1] <= '0;
      waiting_q  <= 1'b1;
      elapsed_q  <= '0;
    end else if (accept_i) begin
      light_q   <= light_d;
      aux_q     <= aux_d;
      waiting_q <= waiting_d;
      elapsed_q <= elapsed_d;
      if (kind_i == KindServo && 32'(option_i) < ServoCount) begin
        servo_q[option_i[0]] <= servo_value_i;
      end
    end
  end

  // frame command
  assign cmd_push_o       = send;
  assign cmd_o.long_frame = !is_short;
  assign cmd_o.code       = cfg_i.protocol_code;
  assign cmd_o.light      = light_q;
  assign cmd_o.aux        = aux_q;
  assign cmd_o.servo0     = servo_q[0];
  assign cmd_o.servo1     = servo_q[1];

  // a sending tick restarts the counter and arms the wait
  a_send_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    send |=> (waiting_q && elapsed_q == '0))
    else $error("sending tick did not restart the counter");
  a_no_send_waiting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (waiting_q && elapsed_q < ElapsedMax && elapsed_q < {1'b0, cfg_i.polling_ms})
      |-> !send)
    else $error("frame sent before the polling interval elapsed");
  a_set_no_send: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (kind_i != KindTick) |-> !cmd_push_o)
    else $error("set item queued a frame");

endmodule

FILE: sv/pfb_cmd_fifo.sv
// ----------------------------------------------------------------------------
// pfb_cmd_fifo
// short queue of frame commands between front and back
// ----------------------------------------------------------------------------
module pfb_cmd_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  pfb_pkg::cmd_t        data_i,
  input  logic                 pop_i,
  output pfb_pkg::cmd_t        data_o,
  output pfb_pkg::fifo_status_t status_o
);
  import pfb_pkg::*;

  cmd_t               mem_q [CmdDepth];
  logic [CmdPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CmdCntW-1:0] count_q;
  logic               do_push, do_pop;

  assign status_o.full  = (count_q == CmdCntW'(CmdDepth));
  assign status_o.empty = (count_q == '0);
  assign do_push = push_i && !status_o.full;
  assign do_pop  = pop_i && !status_o.empty;
  assign data_o  = mem_q[rd_ptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) wr_ptr_q <= (32'(wr_ptr_q) == CmdDepth - 1) ? '0 : wr_ptr_q + 1'b1;
      if (do_pop)  rd_ptr_q <= (32'(rd_ptr_q) == CmdDepth - 1) ? '0 : rd_ptr_q + 1'b1;
      if (do_push && !do_pop)      count_q <= count_q + 1'b1;
      else if (do_pop && !do_push) count_q <= count_q - 1'b1;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) <= CmdDepth)
    else $error("command queue count out of range");
  a_no_lost_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !status_o.full)
    else $error("command pushed into a full queue");
  a_ptr_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0 || 32'(count_q) == CmdDepth) |-> (wr_ptr_q == rd_ptr_q))
    else $error("queue pointers disagree with fill count");

endmodule

FILE: sv/pfb_back.sv
// ----------------------------------------------------------------------------
// pfb_back
// takes frame commands, sends one byte a cycle unless stalled, folds the crc
// ----------------------------------------------------------------------------
module pfb_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  pfb_pkg::cfg_t cfg_i,
  input  logic          cmd_empty_i,
  input  pfb_pkg::cmd_t cmd_i,
  output logic          cmd_pop_o,
  output logic          empty,
  input  logic          pop,
  output logic [7:0]    frame_byte_o,
  output logic          last_byte_o
);
  import pfb_pkg::*;

  // reflected crc over one byte, one bit a step
  function automatic logic [15:0] crc_fold(logic [15:0] crc, logic [7:0] data,
                                           logic [15:0] poly);
    logic [15:0] c;
    c = crc ^ {8'h00, data};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ poly) : (c >> 1);
    end
    return c;
  endfunction

  logic        busy_q;
  logic [3:0]  idx_q, last_idx;
  logic [15:0] crc_q;
  cmd_t        cmd_q;
  logic        out_valid_q, out_last_q;
  logic [7:0]  out_byte_q, cur_byte;
  logic        slot_free, emit, is_crc, is_last;

  assign slot_free = !out_valid_q || pop;
  assign emit      = busy_q && slot_free;
  assign cmd_pop_o = !busy_q && !cmd_empty_i;
  assign last_idx  = cmd_q.long_frame ? LongLast : ShortLast;
  assign is_last   = (idx_q == last_idx);
  assign is_crc    = (idx_q >= last_idx - 4'd1);

  // byte selection by position in the frame
  always_comb begin
    if (is_last) begin
      cur_byte = crc_q[7:0];
    end else if (is_crc) begin
      cur_byte = crc_q[15:8];
    end else begin
      case (idx_q)
        4'd0:    cur_byte = cmd_q.code;
        4'd1:    cur_byte = cmd_q.light;
        4'd2:    cur_byte = cmd_q.aux;
        4'd3:    cur_byte = cmd_q.servo0[15:8];
        4'd4:    cur_byte = cmd_q.servo0[7:0];
        4'd5:    cur_byte = cmd_q.servo1[15:8];
        4'd6:    cur_byte = cmd_q.servo1[7:0];
        default: cur_byte = 8'h00;
      endcase
    end
  end

  // command payload
  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      cmd_q <= cmd_i;
    end
  end

  // sequencer and crc
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
      crc_q  <= CrcInit;
    end else if (cmd_pop_o) begin
      busy_q <= 1'b1;
      idx_q  <= '0;
      crc_q  <= CrcInit;
    end else if (emit) begin
      idx_q <= idx_q + 1'b1;
      if (!is_crc) crc_q <= crc_fold(crc_q, cur_byte, cfg_i.crc_polynomial);
      if (is_last) busy_q <= 1'b0;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (slot_free) begin
      out_valid_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_byte_q <= cur_byte;
      out_last_q <= is_last;
    end
  end

  assign empty        = !out_valid_q;
  assign frame_byte_o = out_byte_q;
  assign last_byte_o  = out_last_q;

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (idx_q <= last_idx))
    else $error("byte index beyond frame end");
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && is_last) |=> (!busy_q && out_last_q))
    else $error("frame did not end on its last byte");
  a_fetch_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |-> !busy_q)
    else $error("command fetched while a frame is in progress");

endmodule

FILE: sv/polled_frame_builder_crc16_core.sv
// ----------------------------------------------------------------------------
// polled_frame_builder_crc16_core
// builds polled light / servo frames with a reflected crc-16
// ----------------------------------------------------------------------------
// Items enter on push/full: a beat is taken when push is high and full low.
// Kinds 1..3 update the light mask, aux mask or a servo word.
// A kind 0 beat is a 1 ms tick; once the count exceeds polling_ms and the
// code matches, it queues a frame (4 bytes light-only or 9 bytes light plus
// servo, crc last, high byte first) in a two-entry command queue. full is
// high while that queue holds two frames.
// Bytes leave on empty/pop: the oldest byte is shown while empty is low and
// taken when pop is high. The back end sends one byte a cycle, while pop
// keeps up, from the command queue via the command register and an output
// register. A stalled receiver stalls only the back end; the front keeps
// taking items until the command queue fills.
// Configuration beats on cfg_valid_i/cfg_ready_o are always taken and are
// meant to be written while no frame is in flight.
// Reset clears the masks, servo words and counter, arms the turnaround wait
// and loads the default codes, polynomial 0xA001 and 50 ms.
// ----------------------------------------------------------------------------
module polled_frame_builder_crc16_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  kind_i,
  input  logic [2:0]  option_i,
  input  logic        bit_value_i,
  input  logic [15:0] servo_value_i,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  frame_byte_o,
  output logic        last_byte_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  import pfb_pkg::*;

  cfg_t         cfg_q;
  cmd_t         cmd_front, cmd_back;
  logic         cmd_push, cmd_pop, accept;
  fifo_status_t fifo_st;

  assign cfg_ready_o = 1'b1;
  assign full        = fifo_st.full;
  assign accept      = push && !full;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.protocol_code    <= 8'd1;
      cfg_q.light_only_code  <= 8'd1;
      cfg_q.light_servo_code <= 8'd2;
      cfg_q.crc_polynomial   <= 16'hA001;
      cfg_q.polling_ms       <= 16'd50;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        RegProtocolCode:   cfg_q.protocol_code    <= cfg_data_i[7:0];
        RegLightOnlyCode:  cfg_q.light_only_code  <= cfg_data_i[7:0];
        RegLightServoCode: cfg_q.light_servo_code <= cfg_data_i[7:0];
        RegCrcPolynomial:  cfg_q.crc_polynomial   <= cfg_data_i;
        RegPollingMs:      cfg_q.polling_ms       <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // front end
  pfb_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .accept_i      (accept),
    .kind_i        (kind_i),
    .option_i      (option_i),
    .bit_value_i   (bit_value_i),
    .servo_value_i (servo_value_i),
    .cmd_push_o    (cmd_push),
    .cmd_o         (cmd_front)
  );

  // command queue
  pfb_cmd_fifo u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (cmd_push),
    .data_i   (cmd_front),
    .pop_i    (cmd_pop),
    .data_o   (cmd_back),
    .status_o (fifo_st)
  );

  // back end
  pfb_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .cmd_empty_i  (fifo_st.empty),
    .cmd_i        (cmd_back),
    .cmd_pop_o    (cmd_pop),
    .empty        (empty),
    .pop          (pop),
    .frame_byte_o (frame_byte_o),
    .last_byte_o  (last_byte_o)
  );

endmodule

FILE: test/polled_frame_builder_crc16_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// polled_frame_builder_crc16_core_tb
// self-checking bench for the polled light / servo frame builder
// ----------------------------------------------------------------------------
// Set items and millisecond ticks go in on push/full, frame bytes come back
// on empty/pop. A scoreboard object tracks the masks, servo words, the
// turnaround hold-off and the millisecond count, builds every frame with its
// crc and checks each popped byte in order. Directed items cover the field
// extremes, both frame types, unknown and equal codes and the longest
// polling interval; random items follow under changing register settings
// while both sides idle at random, then with neither side idling.
// ----------------------------------------------------------------------------
module polled_frame_builder_crc16_core_tb;
  import pfb_pkg::*;

  localparam int unsigned CycleLimit  = 1_000_000;
  localparam int unsigned DrainCycles = 24;
  localparam int unsigned RandomItems = 38;

  // one expected byte of a frame
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } frame_beat_t;

  // tracks the block state and holds the bytes still to come
  class frame_scoreboard;
    cfg_t        regs;
    logic        holdoff;
    logic [ElapsedW-1:0] ms_since_frame;
    logic [7:0]  lights;
    logic [7:0]  aux_bits;
    logic [15:0] servo_us [2];
    frame_beat_t expected_bytes [$];
    int unsigned mismatches;
    int unsigned bytes_checked;
    int unsigned frames_checked;

    function new();
      regs.protocol_code    = 8'd1;
      regs.light_only_code  = 8'd1;
      regs.light_servo_code = 8'd2;
      regs.crc_polynomial   = 16'hA001;
      regs.polling_ms       = 16'd50;
      holdoff        = 1'b1;
      ms_since_frame = '0;
      lights         = '0;
      aux_bits       = '0;
      servo_us[0]    = '0;
      servo_us[1]    = '0;
      mismatches     = 0;
      bytes_checked  = 0;
      frames_checked = 0;
    endfunction

    task report(input string what);
      if (mismatches < 50) begin
        $display("mismatch: %s", what);
      end
      mismatches++;
    endtask

    function int unsigned pending();
      return expected_bytes.size();
    endfunction

    function void note_config(input logic [2:0] index, input logic [15:0] data);
      case (index)
        RegProtocolCode:   regs.protocol_code    = data[7:0];
        RegLightOnlyCode:  regs.light_only_code  = data[7:0];
        RegLightServoCode: regs.light_servo_code = data[7:0];
        RegCrcPolynomial:  regs.crc_polynomial   = data;
        RegPollingMs:      regs.polling_ms       = data;
        default: ;
      endcase
    endfunction

    // reflected crc-16, one byte folded lsb first
    function logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] data);
      int i;
      crc = crc ^ {8'h00, data};
      for (i = 0; i < 8; i++) begin
        crc = crc[0] ? ((crc >> 1) ^ regs.crc_polynomial) : (crc >> 1);
      end
      return crc;
    endfunction

    // one millisecond: count, release the hold-off, maybe build a frame
    function void advance_ms();
      logic [7:0]  frame [9];
      logic [15:0] crc;
      frame_beat_t beat;
      int          len;
      int          i;
      if (ms_since_frame != ElapsedMax) begin
        ms_since_frame++;
      end
      if (holdoff && ms_since_frame > {1'b0, regs.polling_ms}) begin
        holdoff = 1'b0;
      end
      if (holdoff) begin
        return;
      end
      if (regs.protocol_code == regs.light_only_code) begin
        len = 4;
      end else if (regs.protocol_code == regs.light_servo_code) begin
        len = 9;
      end else begin
        return;
      end
      frame[0] = regs.protocol_code;
      frame[1] = lights;
      frame[2] = aux_bits;
      frame[3] = servo_us[0][15:8];
      frame[4] = servo_us[0][7:0];
      frame[5] = servo_us[1][15:8];
      frame[6] = servo_us[1][7:0];
      crc = CrcInit;
      for (i = 0; i < len - 2; i++) begin
        crc = crc_fold(crc, frame[i]);
      end
      frame[len-2] = crc[15:8];
      frame[len-1] = crc[7:0];
      for (i = 0; i < len; i++) begin
        beat.data = frame[i];
        beat.last = (i == len - 1);
        expected_bytes.push_back(beat);
      end
      holdoff        = 1'b1;
      ms_since_frame = '0;
    endfunction

    function void note_item(input logic [1:0] kind, input logic [2:0] option,
                            input logic bit_value, input logic [15:0] servo_value);
      case (kind)
        KindTick:  advance_ms();
        KindLight: lights[option] = bit_value;
        KindAux:   aux_bits[option] = bit_value;
        default: begin
          if (option < ServoCount) begin
            servo_us[option[0]] = servo_value;
          end
        end
      endcase
    endfunction

    task check_byte(input logic [7:0] data, input logic last);
      frame_beat_t want;
      if (expected_bytes.size() == 0) begin
        report($sformatf("byte %02h (last %b) with nothing expected", data, last));
        return;
      end
      want = expected_bytes.pop_front();
      if (data !== want.data) begin
        report($sformatf("byte %0d: frame_byte %02h, expected %02h",
                         bytes_checked, data, want.data));
      end
      if (last !== want.last) begin
        report($sformatf("byte %0d: last_byte %b, expected %b",
                         bytes_checked, last, want.last));
      end
      bytes_checked++;
      if (want.last) begin
        frames_checked++;
      end
    endtask
  endclass

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        push          = 1'b0;
  logic        full;
  logic [1:0]  kind_i        = KindTick;
  logic [2:0]  option_i      = '0;
  logic        bit_value_i   = 1'b0;
  logic [15:0] servo_value_i = '0;
  logic        empty;
  logic        pop           = 1'b0;
  logic [7:0]  frame_byte_o;
  logic        last_byte_o;
  logic        cfg_valid_i   = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i   = RegProtocolCode;
  logic [15:0] cfg_data_i    = '0;

  frame_scoreboard sb = new();
  int unsigned tx_idle_pct   = 35;
  int unsigned rx_idle_pct   = 54;
  int unsigned items_taken   = 0;
  int unsigned config_writes = 0;
  int unsigned cycle_count   = 0;

  polled_frame_builder_crc16_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .kind_i        (kind_i),
    .option_i      (option_i),
    .bit_value_i   (bit_value_i),
    .servo_value_i (servo_value_i),
    .empty         (empty),
    .pop           (pop),
    .frame_byte_o  (frame_byte_o),
    .last_byte_o   (last_byte_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // clock
  always #4 clk_i = ~clk_i;

  // receiver: pop at random
  always @(posedge clk_i) begin
    pop <= ($urandom_range(99) >= rx_idle_pct);
  end

  // check every byte beat taken at this edge
  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      sb.check_byte(frame_byte_o, last_byte_o);
    end
  end

  // watchdog
  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d bytes still expected",
             cycle_count, sb.pending());
    $display("CHECKS FAILED");
    $finish;
  end

  // one input beat, with random idle cycles in front; called at a clock edge
  task automatic send_item(input logic [1:0] kind, input logic [2:0] option,
                           input logic bit_value, input logic [15:0] servo_value);
    while ($urandom_range(99) < tx_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push          <= 1'b1;
    kind_i        <= kind;
    option_i      <= option;
    bit_value_i   <= bit_value;
    servo_value_i <= servo_value;
    @(posedge clk_i);
    while (full) begin
      @(posedge clk_i);
    end
    sb.note_item(kind, option, bit_value, servo_value);
    items_taken++;
  endtask

  task automatic send_tick();
    send_item(KindTick, 3'($urandom_range(7)), 1'($urandom_range(1)), 16'($urandom()));
  endtask

  // stop pushing and let every expected byte drain
  task automatic wait_idle();
    push <= 1'b0;
    while (sb.pending() != 0) begin
      @(posedge clk_i);
    end
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // write all five registers, then one unused index
  task automatic write_config(input cfg_t c);
    logic [2:0]  index [6];
    logic [15:0] value [6];
    int          i;
    index[0] = RegProtocolCode;
    index[1] = RegLightOnlyCode;
    index[2] = RegLightServoCode;
    index[3] = RegCrcPolynomial;
    index[4] = RegPollingMs;
    index[5] = RegPollingMs + 3'($urandom_range(1, 3));
    value[0] = {8'($urandom_range(255)), c.protocol_code};
    value[1] = {8'($urandom_range(255)), c.light_only_code};
    value[2] = {8'($urandom_range(255)), c.light_servo_code};
    value[3] = c.crc_polynomial;
    value[4] = c.polling_ms;
    value[5] = 16'($urandom());
    for (i = 0; i < 6; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= index[i];
      cfg_data_i  <= value[i];
      @(posedge clk_i);
      while (!cfg_ready_o) begin
        @(posedge clk_i);
      end
      sb.note_config(index[i], value[i]);
      config_writes++;
    end
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_config(input logic [7:0] code, input logic [7:0] lo_code,
                            input logic [7:0] ls_code, input logic [15:0] poly,
                            input logic [15:0] poll);
    cfg_t c;
    c.protocol_code    = code;
    c.light_only_code  = lo_code;
    c.light_servo_code = ls_code;
    c.crc_polynomial   = poly;
    c.polling_ms       = poll;
    wait_idle();
    write_config(c);
  endtask

  // random settings, then a run of random items
  task automatic random_phase();
    cfg_t        c;
    int unsigned r;
    logic [2:0]  o;
    int          n;
    c.light_only_code  = 8'($urandom_range(255));
    c.light_servo_code = 8'($urandom_range(255));
    case ($urandom_range(9))
      0:       c.protocol_code = 8'($urandom_range(255));
      1: begin
        c.protocol_code    = c.light_only_code;
        c.light_servo_code = c.light_only_code;
      end
      2, 3, 4: c.protocol_code = c.light_only_code;
      default: c.protocol_code = c.light_servo_code;
    endcase
    c.crc_polynomial = ($urandom_range(3) == 0) ? 16'hA001 : 16'($urandom());
    c.polling_ms     = ($urandom_range(5) == 0) ? 16'($urandom_range(12))
                                                : 16'($urandom_range(3));
    wait_idle();
    write_config(c);
    for (n = 0; n < RandomItems; n++) begin
      r = $urandom_range(99);
      o = 3'($urandom_range(7));
      if (r < 50) begin
        send_tick();
      end else if (r < 65) begin
        send_item(KindLight, o, 1'($urandom_range(1)), 16'($urandom()));
      end else if (r < 80) begin
        send_item(KindAux, o, 1'($urandom_range(1)), 16'($urandom()));
      end else begin
        if ($urandom_range(4) != 0) begin
          o = 3'($urandom_range(1));
        end
        send_item(KindServo, o, 1'($urandom_range(1)), 16'($urandom()));
      end
    end
  endtask

  initial begin
    int p;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: first frame on the 51st tick
    send_item(KindLight, 3'd0, 1'b1, 16'h0000);
    repeat (51) send_tick();

    // light-only frames on every tick, field extremes in the masks and servos
    set_config(8'd1, 8'd1, 8'd2, 16'hA001, 16'd0);
    send_item(KindLight, 3'd7, 1'b1, 16'hFFFF);
    send_item(KindLight, 3'd3, 1'b1, 16'h0000);
    send_item(KindLight, 3'd3, 1'b0, 16'hFFFF);
    send_item(KindAux, 3'd7, 1'b1, 16'h0000);
    send_item(KindAux, 3'd0, 1'b1, 16'hFFFF);
    send_item(KindServo, 3'd0, 1'b0, 16'hFFFF);
    send_item(KindServo, 3'd1, 1'b1, 16'h0001);
    // servo numbers out of range are dropped
    send_item(KindServo, 3'd2, 1'b0, 16'h1234);
    send_item(KindServo, 3'd7, 1'b1, 16'hBEEF);
    send_tick();
    send_tick();

    // light plus servo frame, all-ones polynomial
    set_config(8'd2, 8'd1, 8'd2, 16'hFFFF, 16'd1);
    send_item(KindLight, 3'd7, 1'b0, 16'h0000);
    send_tick();
    send_tick();
    send_tick();

    // unknown code sends nothing and keeps retrying, then a code that matches
    set_config(8'hFF, 8'h00, 8'h00, 16'h0000, 16'd2);
    repeat (4) send_tick();
    set_config(8'h00, 8'h00, 8'h03, 16'h0000, 16'd2);
    send_tick();
    send_tick();

    // both codes equal: the short frame wins
    set_config(8'h80, 8'h80, 8'h80, 16'hFFFF, 16'd0);
    send_tick();
    send_tick();

    // longest polling interval holds every frame back
    set_config(8'h80, 8'h80, 8'h80, 16'hFFFF, 16'hFFFF);
    repeat (3) send_tick();

    // random part under three idling regimes
    for (p = 0; p < 3; p++) random_phase();
    tx_idle_pct = 54;
    rx_idle_pct = 35;
    for (p = 0; p < 3; p++) random_phase();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    for (p = 0; p < 3; p++) random_phase();

    wait_idle();
    $display("covered %0d input beats, %0d register writes, %0d frames / %0d bytes",
             items_taken, config_writes, sb.frames_checked, sb.bytes_checked);
    $display("both frame types, unknown and shared codes, polling 0 to 65535");
    if (sb.mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/pfb_pkg.sv
sv/pfb_front.sv
sv/pfb_cmd_fifo.sv
sv/pfb_back.sv
sv/polled_frame_builder_crc16_core.sv
test/polled_frame_builder_crc16_core_tb.sv
